/* hw/rtl/esd_pkg.sv */
// esd_pkg: shared types and constants for the earliest-free server dispatch block
// depends on nothing; used by esd_mem, esd_engine and earliest_free_server_dispatch_top

package esd_pkg;

  localparam int unsigned IdxW    = 4;
  localparam int unsigned DurW    = 20;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned ActiveW = 5;

  localparam logic [ActiveW-1:0] ActiveReset = 5'd16;
  localparam logic [DurW-1:0]    DurReset    = 20'hF_FFFF;
  localparam logic [TimeW-1:0]   TimeMax     = 48'hFFFF_FFFF_FFFF;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_DISPATCH = 1'b1
  } esd_op_e;

  // one server entry: service duration and next-free time
  typedef struct packed {
    logic [DurW-1:0]  dur;
    logic [TimeW-1:0] ft;
  } esd_entry_t;

endpackage

/* hw/rtl/esd_mem.sv */
// esd_mem: server table, one write port and one registered read port
// depends on esd_pkg for the entry type

module esd_mem #(
  parameter int unsigned NUM_SERVERS = 16
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [(NUM_SERVERS > 1 ? $clog2(NUM_SERVERS) : 1)-1:0] wr_addr_i,
  input  esd_pkg::esd_entry_t wr_data_i,
  input  logic                rd_en_i,
  input  logic [(NUM_SERVERS > 1 ? $clog2(NUM_SERVERS) : 1)-1:0] rd_addr_i,
  output esd_pkg::esd_entry_t rd_data_o
);

  esd_pkg::esd_entry_t mem_q [NUM_SERVERS];
  esd_pkg::esd_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/esd_engine.sv */
// esd_engine: clearing sweep, minimum scan over the server table and write-back
// depends on esd_pkg; drives the ports of esd_mem

module esd_engine #(
  parameter int unsigned NUM_SERVERS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [esd_pkg::ActiveW-1:0]       active_i,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode_i,
  input  logic [esd_pkg::IdxW-1:0]          server_index_i,
  input  logic [esd_pkg::DurW-1:0]          service_duration_i,
  output logic                              result_valid_o,
  output logic [esd_pkg::IdxW-1:0]          chosen_server_o,
  output logic [esd_pkg::TimeW-1:0]         start_time_o,
  output logic                              time_overflow_o,
  output logic                              wr_en_o,
  output logic [(NUM_SERVERS > 1 ? $clog2(NUM_SERVERS) : 1)-1:0] wr_addr_o,
  output esd_pkg::esd_entry_t               wr_data_o,
  output logic                              rd_en_o,
  output logic [(NUM_SERVERS > 1 ? $clog2(NUM_SERVERS) : 1)-1:0] rd_addr_o,
  input  esd_pkg::esd_entry_t               rd_data_i
);

  localparam int unsigned AW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(NUM_SERVERS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WB    = 3'd3;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] last_q, last_d;

  logic [AW-1:0]                best_idx_q;
  logic [esd_pkg::TimeW-1:0]    best_ft_q;
  logic [esd_pkg::DurW-1:0]     best_dur_q;
  logic                         best_upd;

  logic                         valid_q, valid_d;
  logic [esd_pkg::IdxW-1:0]     chosen_q;
  logic [esd_pkg::TimeW-1:0]    start_q;
  logic                         ovf_q;

  logic [31:0]                  n_eff;
  logic [31:0]                  idx_ext;
  logic                         load_ok;
  logic [esd_pkg::TimeW:0]      sum;
  logic [esd_pkg::TimeW-1:0]    sat_ft;
  logic                         ovf;

  // number of servers taking part, clamped to one..NUM_SERVERS
  always_comb begin
    n_eff = 32'(active_i);
    if (n_eff == 32'd0) begin
      n_eff = 32'd1;
    end
    if (n_eff > 32'(NUM_SERVERS)) begin
      n_eff = 32'(NUM_SERVERS);
    end
  end

  assign idx_ext = 32'(server_index_i);
  assign load_ok = idx_ext < 32'(NUM_SERVERS);

  assign sum    = {1'b0, best_ft_q} + (esd_pkg::TimeW + 1)'(best_dur_q);
  assign ovf    = sum[esd_pkg::TimeW];
  assign sat_ft = ovf ? esd_pkg::TimeMax : sum[esd_pkg::TimeW-1:0];

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    last_d    = last_q;
    valid_d   = 1'b0;
    best_upd  = 1'b0;
    wr_en_o   = 1'b0;
    wr_addr_o = cur_q;
    wr_data_o = '{dur: esd_pkg::DurReset, ft: '0};
    rd_en_o   = 1'b0;
    rd_addr_o = cur_q;
    case (state_q)
      ST_CLEAR: begin
        wr_en_o = 1'b1;
        if (cur_q == LastAddr) begin
          cur_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cur_d = AW'(cur_q + 1'b1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (esd_pkg::esd_op_e'(opcode_i) == esd_pkg::OP_LOAD) begin
            wr_en_o   = load_ok;
            wr_addr_o = AW'(idx_ext);
            wr_data_o = '{dur: service_duration_i, ft: '0};
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = '0;
            cur_d     = '0;
            last_d    = AW'(n_eff - 32'd1);
            state_d   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        best_upd = (cur_q == '0) || (rd_data_i.ft < best_ft_q);
        if (cur_q == last_q) begin
          state_d = ST_WB;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = AW'(cur_q + 1'b1);
          cur_d     = AW'(cur_q + 1'b1);
        end
      end
      ST_WB: begin
        wr_en_o   = 1'b1;
        wr_addr_o = best_idx_q;
        wr_data_o = '{dur: best_dur_q, ft: sat_ft};
        valid_d   = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cur_q   <= '0;
      last_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      last_q  <= last_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (best_upd) begin
      best_idx_q <= cur_q;
      best_ft_q  <= rd_data_i.ft;
      best_dur_q <= rd_data_i.dur;
    end
    if (state_q == ST_WB) begin
      chosen_q <= esd_pkg::IdxW'(32'(best_idx_q));
      start_q  <= best_ft_q;
      ovf_q    <= ovf;
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign result_valid_o  = valid_q;
  assign chosen_server_o = chosen_q;
  assign start_time_o    = start_q;
  assign time_overflow_o = ovf_q;

  a_idle_write_is_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && wr_en_o) |-> (start && opcode_i == esd_pkg::OP_LOAD))
    else $error("table written while idle without a load request");

  a_result_after_wb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q == ST_WB))
    else $error("result strobe without write-back");

  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cur_q <= last_q))
    else $error("scan pointer past last active server");

  a_dispatch_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == esd_pkg::OP_DISPATCH) |=> busy)
    else $error("dispatch request did not start a scan");

endmodule

/* hw/rtl/earliest_free_server_dispatch_top.sv */
// earliest_free_server_dispatch_top: active count register, engine and server table
// depends on esd_pkg, esd_mem and esd_engine
//
// channel   | handshake                  | payload
// ----------+----------------------------+---------------------------------------------
// config    | cfg_we_i                   | cfg_wdata_i (active_servers)
// request   | start, busy                | opcode_i, server_index_i, service_duration_i
// result    | result_valid_o (strobe)    | chosen_server_o, start_time_o, time_overflow_o
//
// after reset every table entry is cleared with busy high
// a load request is taken and busy stays low
// a dispatch request holds busy through the scan of the n active servers and the
//   write-back; the scan makes one table read per server through the single read port
// the result strobe comes in the first cycle with busy low and cannot be stalled

module earliest_free_server_dispatch_top #(
  parameter int unsigned NUM_SERVERS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [esd_pkg::ActiveW-1:0]       cfg_wdata_i,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode_i,
  input  logic [esd_pkg::IdxW-1:0]          server_index_i,
  input  logic [esd_pkg::DurW-1:0]          service_duration_i,
  output logic                              result_valid_o,
  output logic [esd_pkg::IdxW-1:0]          chosen_server_o,
  output logic [esd_pkg::TimeW-1:0]         start_time_o,
  output logic                              time_overflow_o
);

  localparam int unsigned AW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  logic [esd_pkg::ActiveW-1:0] active_q;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  esd_pkg::esd_entry_t wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  esd_pkg::esd_entry_t rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= esd_pkg::ActiveReset;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  esd_engine #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_engine (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .active_i           (active_q),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .server_index_i     (server_index_i),
    .service_duration_i (service_duration_i),
    .result_valid_o     (result_valid_o),
    .chosen_server_o    (chosen_server_o),
    .start_time_o       (start_time_o),
    .time_overflow_o    (time_overflow_o),
    .wr_en_o            (wr_en),
    .wr_addr_o          (wr_addr),
    .wr_data_o          (wr_data),
    .rd_en_o            (rd_en),
    .rd_addr_o          (rd_addr),
    .rd_data_i          (rd_data)
  );

  esd_mem #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

/* verif/esd_dispatch_checker.sv */
// esd_dispatch_checker: watches the config, request and result ports of the dispatch block,
// keeps its own server table, predicts every dispatch and compares results in order
// depends on esd_pkg
module esd_dispatch_checker
  import esd_pkg::*;
#(
  parameter int unsigned NUM_SERVERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ActiveW-1:0] cfg_wdata_i,
  input  logic               start,
  input  logic               busy,
  input  logic               opcode_i,
  input  logic [IdxW-1:0]    server_index_i,
  input  logic [DurW-1:0]    service_duration_i,
  input  logic               result_valid_i,
  input  logic [IdxW-1:0]    chosen_server_i,
  input  logic [TimeW-1:0]   start_time_i,
  input  logic               time_overflow_i,
  output int                 mismatches_o,
  output int                 outstanding_o
);

  typedef struct packed {
    logic [IdxW-1:0]  server;
    logic [TimeW-1:0] start_t;
    logic             ovf;
  } dispatch_t;

  logic [DurW-1:0]    dur_tbl  [NUM_SERVERS];
  logic [TimeW-1:0]   free_tbl [NUM_SERVERS];
  logic [ActiveW-1:0] active_q;
  dispatch_t          dispatch_q [$];
  int                 mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("checker: mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    dispatch_t      want;
    int unsigned    n;
    int unsigned    best;
    logic [TimeW:0] sum;
    if (!rst_ni) begin
      active_q = ActiveReset;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        dur_tbl[i]  = DurReset;
        free_tbl[i] = '0;
      end
      dispatch_q.delete();
      outstanding_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (dispatch_q.size() == 0) begin
          report_mismatch($sformatf("result from server %0d with no dispatch waiting",
                                    chosen_server_i));
        end else begin
          want = dispatch_q.pop_front();
          if (chosen_server_i !== want.server)
            report_mismatch($sformatf("chosen_server %0d, expected %0d",
                                      chosen_server_i, want.server));
          if (start_time_i !== want.start_t)
            report_mismatch($sformatf("start_time %0h, expected %0h",
                                      start_time_i, want.start_t));
          if (time_overflow_i !== want.ovf)
            report_mismatch($sformatf("time_overflow %0b, expected %0b",
                                      time_overflow_i, want.ovf));
        end
      end
      if (start && !busy) begin
        if (opcode_i == OP_LOAD) begin
          if (server_index_i < NUM_SERVERS) begin
            dur_tbl[server_index_i]  = service_duration_i;
            free_tbl[server_index_i] = '0;
          end
        end else begin
          // active count clamped to 1..NUM_SERVERS
          n = 32'(active_q);
          if (n < 1) n = 1;
          if (n > NUM_SERVERS) n = NUM_SERVERS;
          best = 0;
          for (int unsigned i = 1; i < n; i++) begin
            if (free_tbl[i] < free_tbl[best]) best = i;
          end
          sum = {1'b0, free_tbl[best]} + (TimeW+1)'(dur_tbl[best]);
          want.server  = IdxW'(best);
          want.start_t = free_tbl[best];
          want.ovf     = sum[TimeW];
          free_tbl[best] = want.ovf ? TimeMax : sum[TimeW-1:0];
          dispatch_q.insert(dispatch_q.size(), want);
        end
      end
      if (cfg_we_i) active_q = cfg_wdata_i;
      outstanding_o <= dispatch_q.size();
    end
  end

endmodule

/* verif/testbench.sv */
// testbench: drives loads, dispatches and active count writes into the dispatch block
// in bursts with random gaps; depends on esd_pkg, the block and esd_dispatch_checker
module testbench;
  import esd_pkg::*;

  localparam int unsigned NumServers   = 16;
  localparam int          CycleLimit   = 400000;
  localparam int          SettleCycles = NumServers + 8;
  localparam int          PhaseItems   = 72;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [ActiveW-1:0] cfg_wdata_i;
  logic               start;
  logic               busy;
  logic               opcode_i;
  logic [IdxW-1:0]    server_index_i;
  logic [DurW-1:0]    service_duration_i;
  logic               result_valid_o;
  logic [IdxW-1:0]    chosen_server_o;
  logic [TimeW-1:0]   start_time_o;
  logic               time_overflow_o;
  int                 mismatches;
  int                 outstanding;
  int                 cycle_count = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  earliest_free_server_dispatch_top #(
    .NUM_SERVERS(NumServers)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .server_index_i     (server_index_i),
    .service_duration_i (service_duration_i),
    .result_valid_o     (result_valid_o),
    .chosen_server_o    (chosen_server_o),
    .start_time_o       (start_time_o),
    .time_overflow_o    (time_overflow_o)
  );

  esd_dispatch_checker #(
    .NUM_SERVERS(NumServers)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .server_index_i     (server_index_i),
    .service_duration_i (service_duration_i),
    .result_valid_i     (result_valid_o),
    .chosen_server_i    (chosen_server_o),
    .start_time_i       (start_time_o),
    .time_overflow_i    (time_overflow_o),
    .mismatches_o       (mismatches),
    .outstanding_o      (outstanding)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // start is left high so back-to-back requests need no extra edge
  task automatic send_request(input esd_op_e op, input logic [IdxW-1:0] idx,
                              input logic [DurW-1:0] dur);
    start              <= 1'b1;
    opcode_i           <= op;
    server_index_i     <= idx;
    service_duration_i <= dur;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 || busy) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [ActiveW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [ActiveW-1:0] act;
    int unsigned        eff;
    int unsigned        sent;
    int unsigned        burst;
    int unsigned        roll;
    esd_op_e            op;
    logic [IdxW-1:0]    idx;
    logic [DurW-1:0]    dur;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    start              <= 1'b0;
    opcode_i           <= OP_LOAD;
    server_index_i     <= '0;
    service_duration_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset durations, ignored fields at both extremes
    send_request(OP_DISPATCH, '1, '1);
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_DISPATCH, 4'h5, 20'hA5A5A);
    // zero duration keeps server 0 at the front
    send_request(OP_LOAD, 4'd0, '0);
    send_request(OP_DISPATCH, 4'hA, 20'h5A5A5);
    send_request(OP_DISPATCH, 4'h3, 20'h00001);
    send_request(OP_LOAD, 4'd15, 20'd1);
    send_request(OP_LOAD, 4'd0, '1);
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_DISPATCH, '0, '0);
    pause(3);
    send_request(OP_LOAD, 4'd10, 20'h5A5A5);
    send_request(OP_DISPATCH, '1, '1);
    send_request(OP_DISPATCH, '1, '1);
    drain();

    // active count of zero, so server 0 alone
    write_active(5'd0);
    send_request(OP_DISPATCH, '1, '0);
    send_request(OP_DISPATCH, '0, '1);
    drain();
    // counts above the table size saturate
    write_active(5'd31);
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_DISPATCH, '0, '0);
    drain();
    write_active(5'd17);
    send_request(OP_LOAD, 4'd15, '0);
    send_request(OP_DISPATCH, '0, '0);
    drain();
    write_active(5'd1);
    send_request(OP_DISPATCH, '0, '0);
    send_request(OP_LOAD, 4'd0, 20'd7);
    send_request(OP_DISPATCH, '0, '0);
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0:       act = ActiveReset;
        1:       act = 5'd1;
        2:       act = 5'd31;
        3:       act = 5'd0;
        default: act = ActiveW'($urandom_range(0, 31));
      endcase
      write_active(act);
      eff = (act == 0) ? 1 : ((act > NumServers) ? NumServers : act);
      sent = 0;
      while (sent < PhaseItems) begin
        burst = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 8);
        for (int b = 0; b < burst && sent < PhaseItems; b++) begin
          op = ($urandom_range(0, 99) < 60) ? OP_DISPATCH : OP_LOAD;
          if (op == OP_LOAD && $urandom_range(0, 3) != 0)
            idx = IdxW'($urandom_range(0, eff - 1));
          else
            idx = IdxW'($urandom_range(0, 15));
          roll = $urandom_range(0, 99);
          if (op == OP_DISPATCH || roll >= 60) dur = DurW'($urandom());
          else if (roll < 5) dur = '0;
          else if (roll < 10) dur = '1;
          else dur = DurW'($urandom_range(1, 64));
          send_request(op, idx, dur);
          sent++;
        end
        if (sent < PhaseItems)
          pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14));
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
